// ===== rtl/core/mas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_pkg
// shared widths, codes, reset values and controller/datapath handshake types
// ----------------------------------------------------------------------------
package mas_pkg;

   // default axis position width
   localparam int POSITION_WIDTH_DEF = 32;

   // fixed field widths
   localparam int OP_W      = 3;
   localparam int DT_W      = 8;
   localparam int LIM_W     = 32;
   localparam int SPEED_W   = 31;
   localparam int VEL_W     = 32;
   localparam int FLAGS_W   = 5;
   localparam int SCALE_W   = 11;
   localparam int ENC_W     = 45;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = VEL_W + DT_W + 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_W-1:0] OP_MOVE_ABS = 3'd1;
   localparam logic [OP_W-1:0] OP_MOVE_REL = 3'd2;
   localparam logic [OP_W-1:0] OP_HOME     = 3'd3;
   localparam logic [OP_W-1:0] OP_JOG      = 3'd4;
   localparam logic [OP_W-1:0] OP_STOP     = 3'd5;
   localparam logic [OP_W-1:0] OP_READ     = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD     = 3'd7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LOW_SOFT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_SOFT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_HARD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_HARD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FLAGS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HOME_SPD  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ENC_SCALE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PARKING   = 3'd7;

   // limit flag bits
   localparam int FLAG_SOFT_LOW  = 0;
   localparam int FLAG_SOFT_HIGH = 1;
   localparam int FLAG_HARD_LOW  = 2;
   localparam int FLAG_HARD_HIGH = 3;
   localparam int FLAG_AMP_LOW   = 4;

   // register reset values
   localparam logic signed [SCALE_W-1:0] ENC_SCALE_RESET = -11'sd57;
   localparam logic signed [LIM_W-1:0]   PARKING_RESET   = -32'sd16384;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic do_cmd;
      logic do_mul;
      logic do_adv;
      logic do_soft;
      logic do_hard;
      logic do_diff;
      logic do_enc;
      logic do_pub;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic            req_valid;
      logic [OP_W-1:0] op;
      logic            out_free;
   } dp_stat_type;

endpackage

// ===== rtl/core/mas_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_if
// command, result and register write channels of the axis simulator
// ----------------------------------------------------------------------------
interface mas_req_if;
   logic                valid;
   logic                ready;
   logic [2:0]          operation;
   logic [7:0]          elapsed_seconds;
   logic signed [31:0]  target;
   logic [30:0]         speed;
   logic                direction;

   modport source (output valid, output operation, output elapsed_seconds,
                   output target, output speed, output direction, input ready);
   modport sink   (input valid, input operation, input elapsed_seconds,
                   input target, input speed, input direction, output ready);
endinterface

interface mas_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  position;
   logic signed [44:0]  encoder_value;
   logic                moving;
   logic                at_home;
   logic                homed;
   logic                low_switch;
   logic                high_switch;
   logic signed [31:0]  velocity;

   modport source (output valid, output position, output encoder_value,
                   output moving, output at_home, output homed, output low_switch,
                   output high_switch, output velocity, input ready);
   modport sink   (input valid, input position, input encoder_value,
                   input moving, input at_home, input homed, input low_switch,
                   input high_switch, input velocity, output ready);
endinterface

interface mas_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mas_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_ctrl
// sequencer that walks one command word through the datapath steps
// ----------------------------------------------------------------------------
module mas_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  mas_pkg::dp_stat_type stat,
   output mas_pkg::dp_cmd_type  cmd
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_CMD  = 9'b000000010,
      ST_MUL  = 9'b000000100,
      ST_ADV  = 9'b000001000,
      ST_SOFT = 9'b000010000,
      ST_HARD = 9'b000100000,
      ST_DIFF = 9'b001000000,
      ST_ENC  = 9'b010000000,
      ST_PUB  = 9'b100000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.req_valid) begin
               priority if (stat.op == mas_pkg::OP_TICK) begin
                  state_in = ST_MUL;
               end else if (stat.op == mas_pkg::OP_READ || stat.op == mas_pkg::OP_RSVD) begin
                  state_in = ST_DIFF;
               end else begin
                  state_in = ST_CMD;
               end
            end
         end
         ST_CMD:  state_in = ST_DIFF;
         ST_MUL:  state_in = ST_ADV;
         ST_ADV:  state_in = ST_SOFT;
         ST_SOFT: state_in = ST_HARD;
         ST_HARD: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_ENC;
         ST_ENC:  state_in = ST_PUB;
         ST_PUB: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.take    = (state_ff == ST_IDLE);
      cmd.do_cmd  = (state_ff == ST_CMD);
      cmd.do_mul  = (state_ff == ST_MUL);
      cmd.do_adv  = (state_ff == ST_ADV);
      cmd.do_soft = (state_ff == ST_SOFT);
      cmd.do_hard = (state_ff == ST_HARD);
      cmd.do_diff = (state_ff == ST_DIFF);
      cmd.do_enc  = (state_ff == ST_ENC);
      cmd.do_pub  = (state_ff == ST_PUB) && stat.out_free;
   end

endmodule

// ===== rtl/core/mas_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_dp
// axis registers, motion arithmetic, limit clamps, encoder scaler, result word
// ----------------------------------------------------------------------------
module mas_dp #(
   parameter int POSITION_WIDTH = mas_pkg::POSITION_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   mas_req_if.sink              req_ch,
   mas_rsp_if.source            rsp_ch,
   mas_csr_if.sink              csr_ch,
   input  mas_pkg::dp_cmd_type  cmd,
   output mas_pkg::dp_stat_type stat
);

   localparam int PW     = POSITION_WIDTH;
   localparam int LW     = mas_pkg::LIM_W;
   localparam int VW     = mas_pkg::VEL_W;
   localparam int SW     = mas_pkg::SPEED_W;
   localparam int PRW    = mas_pkg::PROD_W;
   localparam int KW     = mas_pkg::SCALE_W;
   localparam int NW     = mas_pkg::ENC_W;
   localparam int CW     = ((PW > LW) ? PW : LW) + 2;
   localparam int TW     = ((PW > LW) ? PW : LW) + 1;
   localparam int AW     = ((PW > PRW) ? PW : PRW) + 1;
   localparam int EW     = TW + KW;
   localparam int XW     = ((EW > NW) ? EW : NW) + 1;

   // saturating narrowers
   function automatic logic signed [PW-1:0] sat_c(input logic signed [CW-1:0] x);
      logic signed [CW-1:0] hi;
      logic signed [CW-1:0] lo;
      hi = {{(CW-PW+1){1'b0}}, {(PW-1){1'b1}}};
      lo = {{(CW-PW+1){1'b1}}, {(PW-1){1'b0}}};
      if (x > hi) sat_c = hi[PW-1:0];
      else if (x < lo) sat_c = lo[PW-1:0];
      else sat_c = x[PW-1:0];
   endfunction

   function automatic logic signed [PW-1:0] sat_a(input logic signed [AW-1:0] x);
      logic signed [AW-1:0] hi;
      logic signed [AW-1:0] lo;
      hi = {{(AW-PW+1){1'b0}}, {(PW-1){1'b1}}};
      lo = {{(AW-PW+1){1'b1}}, {(PW-1){1'b0}}};
      if (x > hi) sat_a = hi[PW-1:0];
      else if (x < lo) sat_a = lo[PW-1:0];
      else sat_a = x[PW-1:0];
   endfunction

   function automatic logic signed [LW-1:0] sat_32(input logic signed [CW-1:0] x);
      logic signed [CW-1:0] hi;
      logic signed [CW-1:0] lo;
      hi = {{(CW-LW+1){1'b0}}, {(LW-1){1'b1}}};
      lo = {{(CW-LW+1){1'b1}}, {(LW-1){1'b0}}};
      if (x > hi) sat_32 = hi[LW-1:0];
      else if (x < lo) sat_32 = lo[LW-1:0];
      else sat_32 = x[LW-1:0];
   endfunction

   function automatic logic signed [NW-1:0] sat_45(input logic signed [XW-1:0] x);
      logic signed [XW-1:0] hi;
      logic signed [XW-1:0] lo;
      hi = {{(XW-NW+1){1'b0}}, {(NW-1){1'b1}}};
      lo = {{(XW-NW+1){1'b1}}, {(NW-1){1'b0}}};
      if (x > hi) sat_45 = hi[NW-1:0];
      else if (x < lo) sat_45 = lo[NW-1:0];
      else sat_45 = x[NW-1:0];
   endfunction

   // configuration registers
   logic signed [LW-1:0]              low_soft_ff, low_soft_in;
   logic signed [LW-1:0]              high_soft_ff, high_soft_in;
   logic signed [LW-1:0]              low_hard_ff, low_hard_in;
   logic signed [LW-1:0]              high_hard_ff, high_hard_in;
   logic [mas_pkg::FLAGS_W-1:0]       flags_ff, flags_in;
   logic [SW-1:0]                     home_spd_ff, home_spd_in;
   logic signed [KW-1:0]              scale_ff, scale_in;
   logic signed [LW-1:0]              parking_ff, parking_in;

   // values derived from configuration
   logic signed [LW-1:0]              home_ff, home_in;
   logic                              lo_def_ff, lo_def_in;
   logic                              hi_def_ff, hi_def_in;
   logic signed [LW-1:0]              lo_lim_ff, lo_lim_in;
   logic signed [LW-1:0]              hi_lim_ff, hi_lim_in;
   logic                              soft_en_ff, soft_en_in;
   logic                              hard_en_ff, hard_en_in;

   // axis state
   logic signed [PW-1:0]              pos_ff, pos_in;
   logic signed [PW-1:0]              target_ff, target_in;
   logic signed [VW-1:0]              jog_ff, jog_in;
   logic signed [VW-1:0]              mv_ff, mv_in;
   logic signed [VW-1:0]              hv_ff, hv_in;
   logic                              homed_ff, homed_in;

   // latched command word and work registers
   logic [mas_pkg::OP_W-1:0]          op_ff, op_in;
   logic [mas_pkg::DT_W-1:0]          dt_ff, dt_in;
   logic signed [LW-1:0]              tgt_ff, tgt_in;
   logic [SW-1:0]                     spd_ff, spd_in;
   logic                              dir_ff, dir_in;
   logic signed [PRW-1:0]             prod_ff, prod_in;
   logic signed [CW-1:0]              work_ff, work_in;
   logic signed [TW-1:0]              diff_ff, diff_in;
   logic signed [EW-1:0]              enc_ff, enc_in;

   // result word
   logic                              out_valid_ff, out_valid_in;
   logic signed [LW-1:0]              out_pos_ff, out_pos_in;
   logic signed [NW-1:0]              out_enc_ff, out_enc_in;
   logic                              out_moving_ff, out_moving_in;
   logic                              out_at_home_ff, out_at_home_in;
   logic                              out_homed_ff, out_homed_in;
   logic                              out_lo_sw_ff, out_lo_sw_in;
   logic                              out_hi_sw_ff, out_hi_sw_in;
   logic signed [VW-1:0]              out_vel_ff, out_vel_in;

   // combinational helpers
   logic                              accept;
   logic                              csr_wr;
   logic                              both_soft;
   logic signed [LW:0]                home_sum;
   logic signed [LW-1:0]              home_calc;
   logic                              derived_hard;
   logic signed [LW-1:0]              lo_lim_calc;
   logic signed [LW-1:0]              hi_lim_calc;
   logic signed [CW-1:0]              pos_c;
   logic signed [CW-1:0]              home_c;
   logic signed [TW-1:0]              trel;
   logic signed [PW-1:0]              tsat;
   logic signed [VW-1:0]              spd_s;
   logic [SW-1:0]                     hsp_pick;
   logic [SW-1:0]                     hsp;
   logic signed [VW-1:0]              hsp_s;
   logic signed [VW-1:0]              vsel;
   logic signed [VW-1:0]              vsel_run;
   logic signed [AW-1:0]              sum_a;
   logic signed [PW-1:0]              p_adv;
   logic                              mv_over;
   logic                              hv_over;
   logic signed [CW-1:0]              adv_pos;
   logic signed [CW-1:0]              sw1;
   logic signed [CW-1:0]              sw2;
   logic signed [CW-1:0]              hw1;
   logic signed [CW-1:0]              hw2;

   assign accept = cmd.take && req_ch.valid;
   assign csr_wr = csr_ch.valid && csr_ch.ready;

   assign req_ch.ready = cmd.take;
   assign csr_ch.ready = 1'b1;

   assign stat.req_valid = req_ch.valid;
   assign stat.op        = req_ch.operation;
   assign stat.out_free  = !out_valid_ff || rsp_ch.ready;

   // home point and effective hard limits
   assign both_soft = flags_ff[mas_pkg::FLAG_SOFT_LOW] && flags_ff[mas_pkg::FLAG_SOFT_HIGH];
   assign home_sum  = (LW+1)'(low_soft_ff) + (LW+1)'(high_soft_ff);
   assign home_calc = (!both_soft || (low_soft_ff <= 32'sd0 && high_soft_ff >= 32'sd0)) ?
                      '0 : home_sum[LW:1];
   assign derived_hard = !flags_ff[mas_pkg::FLAG_HARD_LOW] && !flags_ff[mas_pkg::FLAG_HARD_HIGH]
                         && both_soft && (low_soft_ff < high_soft_ff);
   assign lo_lim_calc = derived_hard ? low_soft_ff : low_hard_ff;
   assign hi_lim_calc = derived_hard ? high_soft_ff : high_hard_ff;

   assign pos_c  = CW'(pos_ff);
   assign home_c = CW'(home_ff);

   // command step
   assign trel  = (op_ff == mas_pkg::OP_MOVE_REL) ? TW'(tgt_ff) + TW'(pos_ff) : TW'(tgt_ff);
   assign tsat  = sat_c(CW'(trel));
   assign spd_s = signed'({1'b0, spd_ff});
   assign hsp_pick = (spd_ff != '0) ? spd_ff : home_spd_ff;
   assign hsp   = (home_spd_ff != '0 && hsp_pick > home_spd_ff) ? home_spd_ff : hsp_pick;
   assign hsp_s = signed'({1'b0, hsp});

   // active velocity: jog, then move, then home
   assign vsel = (jog_ff != '0) ? jog_ff : ((mv_ff != '0) ? mv_ff : hv_ff);
   assign vsel_run = flags_ff[mas_pkg::FLAG_AMP_LOW] ? '0 : vsel;

   // advance step, stop at move target or home point when passed
   assign sum_a   = AW'(pos_ff) + AW'(prod_ff);
   assign p_adv   = sat_a(sum_a);
   assign mv_over = (mv_ff > 32'sd0 && p_adv > target_ff) ||
                    (mv_ff < 32'sd0 && p_adv < target_ff);
   assign hv_over = (hv_ff > 32'sd0 && CW'(p_adv) > home_c) ||
                    (hv_ff < 32'sd0 && CW'(p_adv) < home_c);
   assign adv_pos = mv_over ? CW'(target_ff) : (hv_over ? home_c : CW'(p_adv));

   // soft clamp, then hard clamp
   assign sw1 = (soft_en_ff && flags_ff[mas_pkg::FLAG_SOFT_HIGH] && work_ff > CW'(high_soft_ff))
                ? CW'(high_soft_ff) : work_ff;
   assign sw2 = (soft_en_ff && flags_ff[mas_pkg::FLAG_SOFT_LOW] && sw1 < CW'(low_soft_ff))
                ? CW'(low_soft_ff) : sw1;
   assign hw1 = (hard_en_ff && hi_def_ff && work_ff > CW'(hi_lim_ff)) ? CW'(hi_lim_ff) : work_ff;
   assign hw2 = (hard_en_ff && lo_def_ff && hw1 < CW'(lo_lim_ff)) ? CW'(lo_lim_ff) : hw1;

   always_comb begin
      low_soft_in  = low_soft_ff;
      high_soft_in = high_soft_ff;
      low_hard_in  = low_hard_ff;
      high_hard_in = high_hard_ff;
      flags_in     = flags_ff;
      home_spd_in  = home_spd_ff;
      scale_in     = scale_ff;
      parking_in   = parking_ff;
      pos_in       = pos_ff;
      target_in    = target_ff;
      jog_in       = jog_ff;
      mv_in        = mv_ff;
      hv_in        = hv_ff;
      homed_in     = homed_ff;
      op_in        = op_ff;
      dt_in        = dt_ff;
      tgt_in       = tgt_ff;
      spd_in       = spd_ff;
      dir_in       = dir_ff;
      prod_in      = prod_ff;
      work_in      = work_ff;
      diff_in      = diff_ff;
      enc_in       = enc_ff;

      home_in    = home_calc;
      lo_def_in  = derived_hard || flags_ff[mas_pkg::FLAG_HARD_LOW];
      hi_def_in  = derived_hard || flags_ff[mas_pkg::FLAG_HARD_HIGH];
      lo_lim_in  = lo_lim_calc;
      hi_lim_in  = hi_lim_calc;
      soft_en_in = high_soft_ff > low_soft_ff;
      hard_en_in = hi_lim_calc > lo_lim_calc;

      if (csr_wr) begin
         unique case (csr_ch.index)
            mas_pkg::REG_LOW_SOFT:  low_soft_in  = signed'(csr_ch.data);
            mas_pkg::REG_HIGH_SOFT: high_soft_in = signed'(csr_ch.data);
            mas_pkg::REG_LOW_HARD:  low_hard_in  = signed'(csr_ch.data);
            mas_pkg::REG_HIGH_HARD: high_hard_in = signed'(csr_ch.data);
            mas_pkg::REG_FLAGS:     flags_in     = csr_ch.data[mas_pkg::FLAGS_W-1:0];
            mas_pkg::REG_HOME_SPD:  home_spd_in  = csr_ch.data[SW-1:0];
            mas_pkg::REG_ENC_SCALE: scale_in     = signed'(csr_ch.data[KW-1:0]);
            mas_pkg::REG_PARKING: begin
               parking_in = signed'(csr_ch.data);
               pos_in     = sat_c(CW'(signed'(csr_ch.data)));
            end
         endcase
      end

      if (accept) begin
         op_in  = req_ch.operation;
         dt_in  = req_ch.elapsed_seconds;
         tgt_in = req_ch.target;
         spd_in = req_ch.speed;
         dir_in = req_ch.direction;
      end

      if (cmd.do_cmd) begin
         unique case (op_ff)
            mas_pkg::OP_MOVE_ABS, mas_pkg::OP_MOVE_REL: begin
               jog_in    = '0;
               hv_in     = '0;
               target_in = tsat;
               if (tsat > pos_ff) mv_in = spd_s;
               else if (tsat < pos_ff) mv_in = -spd_s;
               else mv_in = '0;
            end
            mas_pkg::OP_HOME: begin
               jog_in   = '0;
               mv_in    = '0;
               homed_in = 1'b0;
               if (home_c > pos_c) hv_in = hsp_s;
               else if (home_c < pos_c) hv_in = -hsp_s;
               else hv_in = '0;
            end
            mas_pkg::OP_JOG: begin
               mv_in  = '0;
               hv_in  = '0;
               jog_in = dir_ff ? spd_s : -spd_s;
            end
            mas_pkg::OP_STOP: begin
               jog_in = '0;
               mv_in  = '0;
               hv_in  = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.do_mul) begin
         // reduced amplifier drops all motion
         if (flags_ff[mas_pkg::FLAG_AMP_LOW]) begin
            jog_in = '0;
            mv_in  = '0;
            hv_in  = '0;
         end
         prod_in = PRW'(vsel_run) * PRW'(signed'({1'b0, dt_ff}));
      end

      if (cmd.do_adv) begin
         work_in = adv_pos;
         if (mv_over) mv_in = '0;
      end

      if (cmd.do_soft) begin
         if (work_ff == home_c) begin
            hv_in    = '0;
            homed_in = 1'b1;
         end
         work_in = sw2;
      end

      if (cmd.do_hard) begin
         pos_in = sat_c(hw2);
      end

      if (cmd.do_diff) begin
         diff_in = TW'(pos_ff) - TW'(parking_ff);
      end

      if (cmd.do_enc) begin
         enc_in = EW'(diff_ff) * EW'(scale_ff);
      end
   end

   // result register
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_pos_in     = out_pos_ff;
      out_enc_in     = out_enc_ff;
      out_moving_in  = out_moving_ff;
      out_at_home_in = out_at_home_ff;
      out_homed_in   = out_homed_ff;
      out_lo_sw_in   = out_lo_sw_ff;
      out_hi_sw_in   = out_hi_sw_ff;
      out_vel_in     = out_vel_ff;
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.do_pub) begin
         out_valid_in   = 1'b1;
         out_pos_in     = sat_32(pos_c);
         out_enc_in     = sat_45(XW'(enc_ff));
         out_moving_in  = (jog_ff != '0) || (mv_ff != '0) || (hv_ff != '0);
         out_at_home_in = (pos_c == home_c);
         out_homed_in   = homed_ff;
         out_lo_sw_in   = lo_def_ff && (pos_c <= CW'(lo_lim_ff));
         out_hi_sw_in   = hi_def_ff && (pos_c >= CW'(hi_lim_ff));
         out_vel_in     = vsel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_soft_ff  <= '0;
         high_soft_ff <= '0;
         low_hard_ff  <= '0;
         high_hard_ff <= '0;
         flags_ff     <= '0;
         home_spd_ff  <= '0;
         scale_ff     <= mas_pkg::ENC_SCALE_RESET;
         parking_ff   <= mas_pkg::PARKING_RESET;
         home_ff      <= '0;
         lo_def_ff    <= 1'b0;
         hi_def_ff    <= 1'b0;
         lo_lim_ff    <= '0;
         hi_lim_ff    <= '0;
         soft_en_ff   <= 1'b0;
         hard_en_ff   <= 1'b0;
         pos_ff       <= sat_c(CW'(mas_pkg::PARKING_RESET));
         target_ff    <= '0;
         jog_ff       <= '0;
         mv_ff        <= '0;
         hv_ff        <= '0;
         homed_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         low_soft_ff  <= low_soft_in;
         high_soft_ff <= high_soft_in;
         low_hard_ff  <= low_hard_in;
         high_hard_ff <= high_hard_in;
         flags_ff     <= flags_in;
         home_spd_ff  <= home_spd_in;
         scale_ff     <= scale_in;
         parking_ff   <= parking_in;
         home_ff      <= home_in;
         lo_def_ff    <= lo_def_in;
         hi_def_ff    <= hi_def_in;
         lo_lim_ff    <= lo_lim_in;
         hi_lim_ff    <= hi_lim_in;
         soft_en_ff   <= soft_en_in;
         hard_en_ff   <= hard_en_in;
         pos_ff       <= pos_in;
         target_ff    <= target_in;
         jog_ff       <= jog_in;
         mv_ff        <= mv_in;
         hv_ff        <= hv_in;
         homed_ff     <= homed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      dt_ff          <= dt_in;
      tgt_ff         <= tgt_in;
      spd_ff         <= spd_in;
      dir_ff         <= dir_in;
      prod_ff        <= prod_in;
      work_ff        <= work_in;
      diff_ff        <= diff_in;
      enc_ff         <= enc_in;
      out_pos_ff     <= out_pos_in;
      out_enc_ff     <= out_enc_in;
      out_moving_ff  <= out_moving_in;
      out_at_home_ff <= out_at_home_in;
      out_homed_ff   <= out_homed_in;
      out_lo_sw_ff   <= out_lo_sw_in;
      out_hi_sw_ff   <= out_hi_sw_in;
      out_vel_ff     <= out_vel_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.position      = out_pos_ff;
   assign rsp_ch.encoder_value = out_enc_ff;
   assign rsp_ch.moving        = out_moving_ff;
   assign rsp_ch.at_home       = out_at_home_ff;
   assign rsp_ch.homed         = out_homed_ff;
   assign rsp_ch.low_switch    = out_lo_sw_ff;
   assign rsp_ch.high_switch   = out_hi_sw_ff;
   assign rsp_ch.velocity      = out_vel_ff;

endmodule

// ===== rtl/core/motion_axis_simulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_axis_simulator
// single motor axis model: commands, timed motion, limits and encoder readback
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  req_ch   in   valid/ready    operation, elapsed_seconds, target, speed, direction
//  rsp_ch   out  valid/ready    position, encoder_value, flags, velocity
//  csr_ch   in   valid/ready    index, data (always ready)
//
//  move/home/jog/stop words pass the command step; the tick runs through the
//  velocity times seconds multiplier, the position adder and the soft and
//  hard clamp steps, then every word passes the encoder subtract and multiplier
//  reset parks the axis and returns configuration and motion registers to defaults
//  one word is worked at a time; a result waiting on rsp_ch sits in its own
//  register so the next req_ch word is taken while the previous one is unread
//  a stalled rsp_ch holds the sequencer in its publish step until the slot frees
// ----------------------------------------------------------------------------
module motion_axis_simulator #(
   parameter int POSITION_WIDTH = mas_pkg::POSITION_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mas_req_if.sink    req_ch,
   mas_rsp_if.source  rsp_ch,
   mas_csr_if.sink    csr_ch
);

   // sequencer to datapath strobes, one per step
   mas_pkg::dp_cmd_type  dp_cmd;
   // request presence, opcode and output slot status back to the sequencer
   mas_pkg::dp_stat_type dp_stat;

   // step sequencer
   mas_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (dp_stat),
      .cmd   (dp_cmd)
   );

   // axis state, arithmetic and result register
   mas_dp #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (dp_cmd),
      .stat   (dp_stat)
   );

   // a taken word closes the request side until its result is published
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken again while a word is in flight");

   // publishing loads the result register
   a_pub_loads: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.do_pub |=> rsp_ch.valid)
      else $error("published word missing on result channel");

   // a nonzero velocity always reports motion
   a_moving_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.velocity != 32'sd0) |-> rsp_ch.moving)
      else $error("velocity reported without moving flag");

   // sequencer only takes words while the request side is open
   a_take_is_ready: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.take |-> (req_ch.ready && !dp_cmd.do_pub))
      else $error("take strobe disagrees with request ready");

endmodule

// ===== tb/motion_axis_simulator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_axis_simulator_test
// self-checking bench for the single axis simulator: a queue fed driver pushes
// command words, a monitor predicts the axis status for every accepted word and
// compares each result word against it, across reset, directed and random
// register settings and with random idling on both channels
// ----------------------------------------------------------------------------
module motion_axis_simulator_test;

   localparam int POS_W     = mas_pkg::POSITION_WIDTH_DEF;
   localparam int WORD_BITS = mas_pkg::LIM_W;
   localparam int DT_BITS   = mas_pkg::DT_W;
   localparam int SPD_BITS  = mas_pkg::SPEED_W;
   localparam int VEL_BITS  = mas_pkg::VEL_W;
   localparam int FLG_BITS  = mas_pkg::FLAGS_W;
   localparam int SCL_BITS  = mas_pkg::SCALE_W;

   // one command word as driven on the request channel
   typedef struct {
      logic [mas_pkg::OP_W-1:0]         operation;
      logic [mas_pkg::DT_W-1:0]         elapsed_seconds;
      logic signed [mas_pkg::LIM_W-1:0] target;
      logic [mas_pkg::SPEED_W-1:0]      speed;
      logic                             direction;
   } axis_cmd_type;

   // one status word as returned on the result channel
   typedef struct {
      logic signed [mas_pkg::LIM_W-1:0] position;
      logic signed [mas_pkg::ENC_W-1:0] encoder_value;
      logic                             moving;
      logic                             at_home;
      logic                             homed;
      logic                             low_switch;
      logic                             high_switch;
      logic signed [mas_pkg::VEL_W-1:0] velocity;
   } axis_status_type;

   // clock and reset
   logic clock;
   logic reset = 1'b1;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // bench side copies of every block input, known from time zero
   axis_cmd_type     req_word = '{default: '0};
   logic             req_valid = 1'b0;
   logic             rsp_ready = 1'b0;
   logic             csr_valid = 1'b0;
   logic [mas_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mas_pkg::LIM_W-1:0]     csr_data = '0;

   mas_req_if req_bus ();
   mas_rsp_if rsp_bus ();
   mas_csr_if csr_bus ();

   assign req_bus.valid           = req_valid;
   assign req_bus.operation       = req_word.operation;
   assign req_bus.elapsed_seconds = req_word.elapsed_seconds;
   assign req_bus.target          = req_word.target;
   assign req_bus.speed           = req_word.speed;
   assign req_bus.direction       = req_word.direction;
   assign rsp_bus.ready           = rsp_ready;
   assign csr_bus.valid           = csr_valid;
   assign csr_bus.index           = csr_index;
   assign csr_bus.data            = csr_data;

   motion_axis_simulator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // words waiting to be driven and status words waiting to come back
   axis_cmd_type    pending_words [$];
   axis_status_type status_due [$];

   int  words_queued = 0;
   int  words_driven = 0;
   int  words_taken = 0;
   int  results_checked = 0;
   int  settings_written = 0;
   int  error_count = 0;

   // idling percentages, changed per phase
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  send_mode [4] = '{0, 70, 0, 18};
   int  recv_mode [4] = '{0, 0, 70, 18};

   // ------------------------------------------------------------------------
   // axis predictor: register copies and motion state at block widths
   // ------------------------------------------------------------------------
   logic signed [mas_pkg::LIM_W-1:0]   cfg_low_soft = '0;
   logic signed [mas_pkg::LIM_W-1:0]   cfg_high_soft = '0;
   logic signed [mas_pkg::LIM_W-1:0]   cfg_low_hard = '0;
   logic signed [mas_pkg::LIM_W-1:0]   cfg_high_hard = '0;
   logic [mas_pkg::FLAGS_W-1:0]        cfg_flags = '0;
   logic [mas_pkg::SPEED_W-1:0]        cfg_home_speed = '0;
   logic signed [mas_pkg::SCALE_W-1:0] cfg_enc_scale = mas_pkg::ENC_SCALE_RESET;
   logic signed [mas_pkg::LIM_W-1:0]   cfg_parking = mas_pkg::PARKING_RESET;

   logic signed [POS_W-1:0]            axis_pos = mas_pkg::PARKING_RESET;
   logic signed [POS_W-1:0]            move_tgt = '0;
   logic signed [mas_pkg::VEL_W-1:0]   jog_vel = '0;
   logic signed [mas_pkg::VEL_W-1:0]   move_vel = '0;
   logic signed [mas_pkg::VEL_W-1:0]   home_vel = '0;
   logic                               homed_flag = 1'b0;

   // clamp to a signed range of w bits
   function automatic longint sat_to(longint x, int w);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic bit both_soft();
      return cfg_flags[mas_pkg::FLAG_SOFT_LOW] && cfg_flags[mas_pkg::FLAG_SOFT_HIGH];
   endfunction

   // home is zero unless both soft limits are on and exclude zero: then the
   // midpoint rounded toward minus infinity
   function automatic longint home_point();
      longint sum;
      longint q;
      if (!both_soft()) return 0;
      if (cfg_low_soft <= 0 && cfg_high_soft >= 0) return 0;
      sum = longint'(cfg_low_soft) + longint'(cfg_high_soft);
      q = sum / 2;
      if (sum < 0 && (sum % 2) != 0) q = q - 1;
      return q;
   endfunction

   // no hard limit defined: they follow a valid soft window
   function automatic bit hard_from_soft();
      return cfg_flags[mas_pkg::FLAG_HARD_HIGH:mas_pkg::FLAG_HARD_LOW] == '0 && both_soft() &&
             cfg_low_soft < cfg_high_soft;
   endfunction

   function automatic bit low_defined();
      return hard_from_soft() || cfg_flags[mas_pkg::FLAG_HARD_LOW];
   endfunction

   function automatic bit high_defined();
      return hard_from_soft() || cfg_flags[mas_pkg::FLAG_HARD_HIGH];
   endfunction

   function automatic longint low_hard_pos();
      return hard_from_soft() ? longint'(cfg_low_soft) : longint'(cfg_low_hard);
   endfunction

   function automatic longint high_hard_pos();
      return hard_from_soft() ? longint'(cfg_high_soft) : longint'(cfg_high_hard);
   endfunction

   function automatic void halt_motion();
      jog_vel = '0;
      move_vel = '0;
      home_vel = '0;
   endfunction

   // one tick: jog, then move, then home motion, then soft and hard clamps
   function automatic void advance_axis(longint dt);
      longint home;
      longint pos;
      home = home_point();
      pos = longint'(axis_pos);
      if (cfg_flags[mas_pkg::FLAG_AMP_LOW]) halt_motion();
      if (jog_vel != 0) pos = sat_to(pos + longint'(jog_vel) * dt, POS_W);
      if (move_vel != 0) begin
         pos = sat_to(pos + longint'(move_vel) * dt, POS_W);
         if ((move_vel > 0 && pos > move_tgt) || (move_vel < 0 && pos < move_tgt)) begin
            pos = longint'(move_tgt);
            move_vel = '0;
         end
      end
      if (home_vel != 0) begin
         pos = sat_to(pos + longint'(home_vel) * dt, POS_W);
         if ((home_vel > 0 && pos > home) || (home_vel < 0 && pos < home)) pos = home;
      end
      if (pos == home) begin
         home_vel = '0;
         homed_flag = 1'b1;
      end
      if (cfg_high_soft > cfg_low_soft) begin
         if (cfg_flags[mas_pkg::FLAG_SOFT_HIGH] && pos > cfg_high_soft) begin
            pos = longint'(cfg_high_soft);
         end
         if (cfg_flags[mas_pkg::FLAG_SOFT_LOW] && pos < cfg_low_soft) begin
            pos = longint'(cfg_low_soft);
         end
      end
      if (high_hard_pos() > low_hard_pos()) begin
         if (high_defined() && pos > high_hard_pos()) pos = high_hard_pos();
         if (low_defined() && pos < low_hard_pos()) pos = low_hard_pos();
      end
      axis_pos = POS_W'(sat_to(pos, POS_W));
   endfunction

   // apply one command word and return the status it reports
   function automatic axis_status_type step_axis(axis_cmd_type c);
      axis_status_type s;
      longint tgt;
      longint spd;
      longint v;
      longint home;
      longint enc;
      spd = longint'(c.speed);
      case (c.operation)
         mas_pkg::OP_TICK: advance_axis(longint'(c.elapsed_seconds));
         mas_pkg::OP_MOVE_ABS, mas_pkg::OP_MOVE_REL: begin
            halt_motion();
            tgt = longint'(c.target);
            if (c.operation == mas_pkg::OP_MOVE_REL) tgt = tgt + longint'(axis_pos);
            tgt = sat_to(tgt, POS_W);
            move_tgt = POS_W'(tgt);
            if (tgt > axis_pos) move_vel = VEL_BITS'(spd);
            else if (tgt < axis_pos) move_vel = VEL_BITS'(-spd);
            else move_vel = '0;
         end
         mas_pkg::OP_HOME: begin
            // zero speed takes the cap as default; a nonzero cap limits it
            v = (spd != 0) ? spd : longint'(cfg_home_speed);
            if (cfg_home_speed != 0 && v > longint'(cfg_home_speed)) begin
               v = longint'(cfg_home_speed);
            end
            halt_motion();
            homed_flag = 1'b0;
            home = home_point();
            if (home > axis_pos) home_vel = VEL_BITS'(v);
            else if (home < axis_pos) home_vel = VEL_BITS'(-v);
            else home_vel = '0;
         end
         mas_pkg::OP_JOG: begin
            halt_motion();
            jog_vel = c.direction ? VEL_BITS'(spd) : VEL_BITS'(-spd);
         end
         mas_pkg::OP_STOP: halt_motion();
         default: ;
      endcase
      home = home_point();
      enc = sat_to((longint'(axis_pos) - longint'(cfg_parking)) * longint'(cfg_enc_scale),
                   mas_pkg::ENC_W);
      s.position      = axis_pos;
      s.encoder_value = enc[mas_pkg::ENC_W-1:0];
      s.moving        = jog_vel != 0 || move_vel != 0 || home_vel != 0;
      s.at_home       = axis_pos == home;
      s.homed         = homed_flag;
      s.low_switch    = low_defined() && axis_pos <= low_hard_pos();
      s.high_switch   = high_defined() && axis_pos >= high_hard_pos();
      s.velocity      = jog_vel != 0 ? jog_vel : (move_vel != 0 ? move_vel : home_vel);
      return s;
   endfunction

   function automatic void apply_register(logic [mas_pkg::CSR_IDX_W-1:0] idx,
                                          logic [mas_pkg::LIM_W-1:0] data);
      case (idx)
         mas_pkg::REG_LOW_SOFT:  cfg_low_soft = data;
         mas_pkg::REG_HIGH_SOFT: cfg_high_soft = data;
         mas_pkg::REG_LOW_HARD:  cfg_low_hard = data;
         mas_pkg::REG_HIGH_HARD: cfg_high_hard = data;
         mas_pkg::REG_FLAGS:     cfg_flags = data[mas_pkg::FLAGS_W-1:0];
         mas_pkg::REG_HOME_SPD:  cfg_home_speed = data[mas_pkg::SPEED_W-1:0];
         mas_pkg::REG_ENC_SCALE: cfg_enc_scale = data[mas_pkg::SCALE_W-1:0];
         mas_pkg::REG_PARKING: begin
            // parking write also moves the axis there
            cfg_parking = data;
            axis_pos = data;
         end
         default: ;
      endcase
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name,
                  $signed(want), $signed(got));
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // driver: a word stays up until taken, then the next one may follow after
   // a random gap
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || words_taken == words_driven) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
            words_driven++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls at random
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // monitor: register writes and command words feed the predictor, result
   // words are checked against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      axis_status_type want;
      axis_cmd_type    seen;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) apply_register(csr_bus.index, csr_bus.data);
         // result first, so a word taken in the same cycle never matches it
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (status_due.size() == 0) begin
               $display("%0t ns: result word with no command word pending", $time);
               error_count++;
            end else begin
               want = status_due.pop_front();
               check_field("position", 64'(want.position), 64'(rsp_bus.position));
               check_field("encoder_value", 64'(want.encoder_value),
                           64'(rsp_bus.encoder_value));
               check_field("moving", 64'(want.moving), 64'(rsp_bus.moving));
               check_field("at_home", 64'(want.at_home), 64'(rsp_bus.at_home));
               check_field("homed", 64'(want.homed), 64'(rsp_bus.homed));
               check_field("low_switch", 64'(want.low_switch), 64'(rsp_bus.low_switch));
               check_field("high_switch", 64'(want.high_switch), 64'(rsp_bus.high_switch));
               check_field("velocity", 64'(want.velocity), 64'(rsp_bus.velocity));
               results_checked++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.operation       = req_bus.operation;
            seen.elapsed_seconds = req_bus.elapsed_seconds;
            seen.target          = req_bus.target;
            seen.speed           = req_bus.speed;
            seen.direction       = req_bus.direction;
            status_due.push_back(step_axis(seen));
            words_taken++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_word(logic [mas_pkg::OP_W-1:0] op, logic [mas_pkg::DT_W-1:0] dt,
                             logic [mas_pkg::LIM_W-1:0] tgt,
                             logic [mas_pkg::SPEED_W-1:0] spd, logic dir);
      axis_cmd_type c;
      c.operation       = op;
      c.elapsed_seconds = dt;
      c.target          = tgt;
      c.speed           = spd;
      c.direction       = dir;
      pending_words.push_back(c);
      words_queued++;
   endtask

   // mostly modest speeds, sometimes zero or full scale
   function automatic logic [mas_pkg::SPEED_W-1:0] random_speed();
      case ($urandom_range(9))
         0: return '0;
         1: return SPD_BITS'($urandom());
         2: return {SPD_BITS{1'b1}};
         default: return SPD_BITS'($urandom_range(1, 'h3FFF));
      endcase
   endfunction

   // all command words have been answered, then the pipeline is let run dry
   task automatic settle_axis();
      while (words_taken != words_queued || status_due.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   // writes every register in index order while the block is idle
   task automatic write_axis_registers(input logic [mas_pkg::LIM_W-1:0] ls, hs, lh, hh,
                                       input logic [mas_pkg::FLAGS_W-1:0] flg,
                                       input logic [mas_pkg::SPEED_W-1:0] hspd,
                                       input logic [mas_pkg::SCALE_W-1:0] scale,
                                       input logic [mas_pkg::LIM_W-1:0] park);
      logic [mas_pkg::CSR_IDX_W-1:0] idx [8];
      logic [mas_pkg::LIM_W-1:0]     val [8];
      idx = '{mas_pkg::REG_LOW_SOFT, mas_pkg::REG_HIGH_SOFT, mas_pkg::REG_LOW_HARD,
              mas_pkg::REG_HIGH_HARD, mas_pkg::REG_FLAGS, mas_pkg::REG_HOME_SPD,
              mas_pkg::REG_ENC_SCALE, mas_pkg::REG_PARKING};
      val = '{ls, hs, lh, hh, {{(WORD_BITS - FLG_BITS){1'b0}}, flg}, {1'b0, hspd},
              {{(WORD_BITS - SCL_BITS){scale[SCL_BITS-1]}}, scale}, park};
      for (int i = 0; i < 8; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   // a motion command with a few ticks behind it, or a noise word
   task automatic queue_random_burst(longint center, longint radius);
      int                       pick;
      int                       ticks;
      logic [mas_pkg::OP_W-1:0] op;
      longint                   tgt;
      pick = $urandom_range(99);
      if (pick < 22) op = mas_pkg::OP_MOVE_ABS;
      else if (pick < 42) op = mas_pkg::OP_MOVE_REL;
      else if (pick < 57) op = mas_pkg::OP_HOME;
      else if (pick < 72) op = mas_pkg::OP_JOG;
      else if (pick < 78) op = mas_pkg::OP_STOP;
      else if (pick < 84) op = mas_pkg::OP_READ;
      else if (pick < 87) op = mas_pkg::OP_RSVD;
      else op = mas_pkg::OP_TICK;
      if ($urandom_range(7) == 0) begin
         tgt = longint'($signed($urandom()));
      end else if (op == mas_pkg::OP_MOVE_REL) begin
         tgt = longint'($urandom_range(0, 32'(2 * radius))) - radius;
      end else begin
         tgt = center + longint'($urandom_range(0, 32'(2 * radius))) - radius;
      end
      queue_word(op, DT_BITS'($urandom()), WORD_BITS'(tgt), random_speed(),
                 1'($urandom_range(1)));
      ticks = (pick < 84) ? $urandom_range(1, 4) : 0;
      repeat (ticks) begin
         queue_word(mas_pkg::OP_TICK,
                    ($urandom_range(9) == 0) ? 8'd255 :
                    ($urandom_range(9) == 0) ? DT_BITS'($urandom_range(0, 255)) :
                                               DT_BITS'($urandom_range(0, 6)),
                    $urandom(), random_speed(), 1'($urandom_range(1)));
      end
   endtask

   // ------------------------------------------------------------------------
   // run sequence
   // ------------------------------------------------------------------------
   initial begin
      longint                      center;
      longint                      radius;
      longint                      ls;
      longint                      hs;
      longint                      lh;
      longint                      hh;
      longint                      park;
      longint                      tmp;
      logic [mas_pkg::FLAGS_W-1:0] flg;
      logic [mas_pkg::SPEED_W-1:0] hspd;
      int                          base;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: parked at its reset value, no limits, default scale
      queue_word(mas_pkg::OP_READ, 8'd0, 32'd0, 31'd0, 1'b0);
      queue_word(mas_pkg::OP_TICK, 8'd0, 32'd0, 31'd0, 1'b0);
      queue_word(mas_pkg::OP_JOG, 8'd0, 32'd0, 31'h100, 1'b1);
      queue_word(mas_pkg::OP_TICK, 8'd255, 32'd0, 31'd0, 1'b0);
      queue_word(mas_pkg::OP_RSVD, 8'd0, 32'd0, 31'd0, 1'b0);
      queue_word(mas_pkg::OP_STOP, 8'd0, 32'd0, 31'd0, 1'b0);
      settle_axis();

      // symmetric soft window holding zero, hard limits follow it
      write_axis_registers(-32'sh8000, 32'sh8000, '0, '0, 5'b00011, 31'h200, 11'sd1023,
                           32'sh4000);
      // home at default speed, then reach it exactly
      queue_word(mas_pkg::OP_HOME, 8'd0, 32'd0, 31'd0, 1'b0);
      queue_word(mas_pkg::OP_TICK, 8'd10, 32'd0, 31'd0, 1'b0);
      queue_word(mas_pkg::OP_TICK, 8'd255, 32'd0, 31'd0, 1'b0);
      // full scale move clamped by the upper soft limit
      queue_word(mas_pkg::OP_MOVE_ABS, 8'd0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      queue_word(mas_pkg::OP_TICK, 8'd1, 32'd0, 31'd0, 1'b0);
      // relative move to the most negative target, position saturates
      queue_word(mas_pkg::OP_MOVE_REL, 8'd0, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b0);
      queue_word(mas_pkg::OP_TICK, 8'd255, 32'd0, 31'd0, 1'b0);
      // move onto the current position has no velocity
      queue_word(mas_pkg::OP_MOVE_ABS, 8'd0, -32'sh8000, 31'd5, 1'b0);
      queue_word(mas_pkg::OP_JOG, 8'd0, 32'd0, 31'd0, 1'b0);
      // home speed above the cap is cut back to it
      queue_word(mas_pkg::OP_HOME, 8'd0, 32'd0, 31'h7FFF_FFFF, 1'b0);
      queue_word(mas_pkg::OP_READ, 8'd0, 32'd0, 31'd0, 1'b1);
      settle_axis();

      // window below zero with an odd negative sum, hard limits defined,
      // amplifier reduced, extreme scale and parking
      write_axis_registers(-32'sh301, -32'sh100, -32'sh200, 32'sh300, 5'b11111, 31'd0,
                           -11'sd1024, 32'sh8000_0000);
      queue_word(mas_pkg::OP_HOME, 8'd0, 32'd0, 31'h40, 1'b0);
      queue_word(mas_pkg::OP_TICK, 8'd3, 32'd0, 31'd0, 1'b0);
      queue_word(mas_pkg::OP_JOG, 8'd0, 32'd0, 31'h7FFF_FFFF, 1'b1);
      queue_word(mas_pkg::OP_TICK, 8'd255, 32'd0, 31'd0, 1'b0);
      queue_word(mas_pkg::OP_READ, 8'd0, 32'd0, 31'd0, 1'b0);
      settle_axis();

      // random phases, each with its own setting and idling mode
      for (int phase = 0; phase < 8; phase++) begin
         center = 0;
         radius = longint'(1 << 20);
         case (phase)
            2: write_axis_registers(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                    32'sh7FFF_FFFF, 5'b01111, 31'h7FFF_FFFF, -11'sd1024,
                                    32'sh8000_0000);
            5: write_axis_registers(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                    32'sh8000_0000, 5'b11111, 31'd0, 11'sd1023,
                                    32'sh7FFF_FFFF);
            default: begin
               center = longint'($urandom_range(0, 1 << 21)) - longint'(1 << 20);
               radius = longint'($urandom_range(256, 1 << 20));
               ls = center - longint'($urandom_range(0, 32'(radius)));
               hs = center + longint'($urandom_range(0, 32'(radius)));
               // inverted or empty windows disable clipping
               if ($urandom_range(5) == 0) begin
                  tmp = ls;
                  ls = hs;
                  hs = tmp;
               end
               if ($urandom_range(9) == 0) hs = ls;
               lh = ls - longint'($urandom_range(0, 1024));
               hh = hs + longint'($urandom_range(0, 1024));
               if ($urandom_range(3) == 0) begin
                  lh = longint'($signed($urandom()));
                  hh = longint'($signed($urandom()));
               end
               flg = FLG_BITS'($urandom_range(0, 15));
               if ($urandom_range(5) == 0) flg[mas_pkg::FLAG_AMP_LOW] = 1'b1;
               case ($urandom_range(3))
                  0: hspd = '0;
                  1: hspd = SPD_BITS'($urandom());
                  default: hspd = SPD_BITS'($urandom_range(1, 'h3FFF));
               endcase
               if ($urandom_range(5) == 0) begin
                  park = longint'($signed($urandom()));
               end else begin
                  park = center + longint'($urandom_range(0, 32'(2 * radius))) - radius;
               end
               write_axis_registers(WORD_BITS'(ls), WORD_BITS'(hs), WORD_BITS'(lh),
                                    WORD_BITS'(hh), flg, hspd, SCL_BITS'($urandom()),
                                    WORD_BITS'(park));
            end
         endcase
         send_idle_pct = send_mode[phase % 4];
         recv_stall_pct = recv_mode[phase % 4];
         base = words_queued;
         while (words_queued - base < 88) queue_random_burst(center, radius);
         // sender holds off until every status word is back
         settle_axis();
      end

      $display("checked %0d status words for %0d command words under %0d register settings",
               results_checked, words_taken, settings_written);
      $display("idling covered none, sender only, receiver only and both at once");
      if (error_count == 0) begin
         $display("motion_axis_simulator_test: clean");
      end else begin
         $display("motion_axis_simulator_test: errors");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #(5_000_000);
      $display("timeout with %0d status words outstanding", status_due.size());
      $display("motion_axis_simulator_test: errors");
      $finish;
   end

endmodule
